// File: rtl/core/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg
// Shared types and constants for the box collision push-out block.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int FRAC_BITS       = 16;
    localparam int SIZE_WIDTH      = 31;
    localparam int AXES            = 3;
    localparam int AXIS_WIDTH      = 2;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int SUM_WIDTH  = SIZE_WIDTH + 1;
    localparam int NP_WIDTH   =
        ((COORD_WIDTH > SIZE_WIDTH + 1) ? COORD_WIDTH : SIZE_WIDTH + 1) + 2;
    localparam int CMP_WIDTH  = NP_WIDTH + 1;

    localparam int EPS_Q = ((1 << FRAC_BITS) + 50) / 100;

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = SIZE_WIDTH'(1 << FRAC_BITS);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_OBSTACLE = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic [SIZE_WIDTH-1:0]         extent_x;
        logic [SIZE_WIDTH-1:0]         extent_y;
        logic [SIZE_WIDTH-1:0]         extent_z;
        logic                          is_box;
        logic                          floating_in;
        logic                          frame_last;
    } acp_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] mover_x;
        logic signed [COORD_WIDTH-1:0] mover_y;
        logic signed [COORD_WIDTH-1:0] mover_z;
        logic                          standing_on;
        logic                          pushed_out;
        logic                          floating_out;
        logic                          done_last;
    } acp_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_ABS,
        S_CMP,
        S_CHECK,
        S_MUL_A,
        S_MUL_B,
        S_SEL,
        S_PUSH,
        S_FINISH
    } acp_state_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } acp_mul_ctrl_t;

endpackage

// File: rtl/core/acp_ratio_unit.sv
// ----------------------------------------------------------------------------
// acp_ratio_unit
// Shared multiplier for the cross-multiplied ratio compare; holds both
// products and flags the first as strictly larger.
// ----------------------------------------------------------------------------
module acp_ratio_unit (
    input  logic                          clk,
    input  acp_pkg::acp_mul_ctrl_t        ctrl,
    input  logic [acp_pkg::SIZE_WIDTH-1:0] op_a,
    input  logic [acp_pkg::SIZE_WIDTH-1:0] op_b,
    output logic                          ratio_gt
);

    localparam int PROD_WIDTH = 2 * acp_pkg::SIZE_WIDTH;

    logic [PROD_WIDTH-1:0] product;
    logic [PROD_WIDTH-1:0] prod_a_reg;
    logic [PROD_WIDTH-1:0] prod_b_reg;

    assign product = PROD_WIDTH'(op_a) * PROD_WIDTH'(op_b);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            prod_a_reg <= product;
        end
        if (ctrl.load_b)
        begin
            prod_b_reg <= product;
        end
    end

    assign ratio_gt = prod_a_reg > prod_b_reg;

endmodule

// File: rtl/core/aabb_collision_pushout_top.sv
// ----------------------------------------------------------------------------
// aabb_collision_pushout_top
// Pushes one movable box out of a stream of fixed obstacle boxes, Q16.16.
// ----------------------------------------------------------------------------
// One word at a time. A load word and a non-box obstacle go from idle
// straight to the post step. A box obstacle runs a difference, an absolute
// value and a compare step per axis for the overlap test, then a check step;
// on full overlap, per axis, it forms the two products in turn on the shared
// multiplier and runs a select step for the distance-to-size ratio compare,
// then a push step, and last it posts the result and goes back to idle. A
// stalled result holds the sequencer in the post step. The result waits in an
// output register, so the next word is taken once the sequencer is in idle.
module aabb_collision_pushout_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  acp_pkg::acp_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output acp_pkg::acp_out_t                  out_data,
    input  logic                               cfg_wen,
    input  logic [acp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [acp_pkg::SIZE_WIDTH-1:0]      cfg_wdata
);

    localparam int CW = acp_pkg::COORD_WIDTH;
    localparam int SW = acp_pkg::SIZE_WIDTH;

    acp_pkg::acp_state_t state_reg;
    acp_pkg::acp_state_t state_next;

    acp_pkg::acp_in_t  in_reg;
    acp_pkg::acp_out_t out_data_reg;
    logic              out_valid_reg;

    logic signed [CW-1:0]                  mover_pos_reg [acp_pkg::AXES];
    logic [SW-1:0]                         mover_size_reg [acp_pkg::AXES];
    logic                                  floating_reg;
    logic                                  any_support_reg;

    logic [acp_pkg::AXIS_WIDTH-1:0]        ax_reg;
    logic [acp_pkg::AXIS_WIDTH-1:0]        best_reg;
    logic                                  best_inf_reg;
    logic [SW-1:0]                         best_d_reg;
    logic [SW-1:0]                         best_s_reg;
    logic signed [acp_pkg::DIFF_WIDTH-1:0] diff_reg;
    logic [acp_pkg::DIFF_WIDTH-1:0]        d_reg [acp_pkg::AXES];
    logic [acp_pkg::SUM_WIDTH-1:0]         sum_reg [acp_pkg::AXES];
    logic [acp_pkg::AXES-1:0]              neg_reg;
    logic [acp_pkg::AXES-1:0]              ovl_reg;
    logic                                  gap_reg;
    logic                                  standing_reg;
    logic                                  pushed_reg;
    logic                                  last_reg;

    logic                                  in_accept;
    logic                                  out_free;
    logic signed [CW-1:0]                  cur_center;
    logic [SW-1:0]                         cur_extent;
    logic [SW-1:0]                         d_small;
    logic signed [acp_pkg::DIFF_WIDTH-1:0] diff_calc;
    logic [acp_pkg::CMP_WIDTH-1:0]         twice_d;
    logic [acp_pkg::CMP_WIDTH-1:0]         sum_ext;
    logic [acp_pkg::SUM_WIDTH:0]           half;
    logic signed [acp_pkg::NP_WIDTH-1:0]   np;
    logic signed [CW-1:0]                  np_sat;
    logic                                  take_inf;
    logic                                  take_ratio;
    logic [acp_pkg::AXIS_WIDTH-1:0]        best_sel;
    logic                                  support_fin;
    logic                                  floating_fin;

    acp_pkg::acp_mul_ctrl_t                mul_ctrl;
    logic [SW-1:0]                         mul_a;
    logic [SW-1:0]                         mul_b;
    logic                                  ratio_gt;

    acp_ratio_unit u_ratio (
        .clk      (clk),
        .ctrl     (mul_ctrl),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .ratio_gt (ratio_gt)
    );

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        case (ax_reg)
            acp_pkg::AXIS_X:
            begin
                cur_center = in_reg.center_x;
                cur_extent = in_reg.extent_x;
            end
            acp_pkg::AXIS_Y:
            begin
                cur_center = in_reg.center_y;
                cur_extent = in_reg.extent_y;
            end
            default:
            begin
                cur_center = in_reg.center_z;
                cur_extent = in_reg.extent_z;
            end
        endcase
    end

    assign d_small   = SW'(d_reg[ax_reg]);
    assign diff_calc = acp_pkg::DIFF_WIDTH'(cur_center) -
                       acp_pkg::DIFF_WIDTH'(mover_pos_reg[ax_reg]);
    assign twice_d   = acp_pkg::CMP_WIDTH'({d_reg[ax_reg], 1'b0});
    assign sum_ext   = acp_pkg::CMP_WIDTH'(sum_reg[ax_reg]);
    assign half      = (acp_pkg::SUM_WIDTH'(sum_reg[ax_reg]) + 1'b1) >> 1;

    always_comb
    begin
        if (neg_reg[ax_reg])
        begin
            np = acp_pkg::NP_WIDTH'(cur_center) +
                 $signed(acp_pkg::NP_WIDTH'(half));
        end
        else
        begin
            np = acp_pkg::NP_WIDTH'(cur_center) -
                 $signed(acp_pkg::NP_WIDTH'(half));
        end
        if (np > acp_pkg::NP_WIDTH'(acp_pkg::COORD_MAX))
        begin
            np_sat = CW'(acp_pkg::COORD_MAX);
        end
        else if (np < acp_pkg::NP_WIDTH'(acp_pkg::COORD_MIN))
        begin
            np_sat = CW'(acp_pkg::COORD_MIN);
        end
        else
        begin
            np_sat = CW'(np);
        end
    end

    assign take_inf   = (cur_extent == '0) && !best_inf_reg;
    assign take_ratio = (cur_extent != '0) && !best_inf_reg && ratio_gt;
    assign best_sel   = (take_inf || take_ratio) ? ax_reg : best_reg;

    assign support_fin  = any_support_reg || standing_reg;
    assign floating_fin = floating_reg || (last_reg && !support_fin);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            acp_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.req_type == acp_pkg::REQ_OBSTACLE && in_data.is_box)
                    begin
                        state_next = acp_pkg::S_DIFF;
                    end
                    else
                    begin
                        state_next = acp_pkg::S_FINISH;
                    end
                end
            end
            acp_pkg::S_DIFF:  state_next = acp_pkg::S_ABS;
            acp_pkg::S_ABS:   state_next = acp_pkg::S_CMP;
            acp_pkg::S_CMP:
            begin
                state_next = (ax_reg == acp_pkg::AXIS_Z) ? acp_pkg::S_CHECK
                                                         : acp_pkg::S_DIFF;
            end
            acp_pkg::S_CHECK:
            begin
                state_next = (&ovl_reg) ? acp_pkg::S_MUL_A : acp_pkg::S_FINISH;
            end
            acp_pkg::S_MUL_A: state_next = acp_pkg::S_MUL_B;
            acp_pkg::S_MUL_B: state_next = acp_pkg::S_SEL;
            acp_pkg::S_SEL:
            begin
                state_next = (ax_reg == acp_pkg::AXIS_Z) ? acp_pkg::S_PUSH
                                                         : acp_pkg::S_MUL_A;
            end
            acp_pkg::S_PUSH:  state_next = acp_pkg::S_FINISH;
            acp_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = acp_pkg::S_IDLE;
                end
            end
            default:          state_next = acp_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall        = 1'b1;
        mul_ctrl.load_a = 1'b0;
        mul_ctrl.load_b = 1'b0;
        mul_a           = d_small;
        mul_b           = best_s_reg;
        case (state_reg)
            acp_pkg::S_IDLE:  in_stall = 1'b0;
            acp_pkg::S_MUL_A: mul_ctrl.load_a = 1'b1;
            acp_pkg::S_MUL_B:
            begin
                mul_ctrl.load_b = 1'b1;
                mul_a           = best_d_reg;
                mul_b           = cur_extent;
            end
            default:          in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= acp_pkg::S_IDLE;
            out_valid_reg   <= 1'b0;
            floating_reg    <= 1'b0;
            any_support_reg <= 1'b0;
            ax_reg          <= acp_pkg::AXIS_X;
            best_reg        <= acp_pkg::AXIS_X;
            best_inf_reg    <= 1'b0;
            neg_reg         <= '0;
            ovl_reg         <= '0;
            gap_reg         <= 1'b0;
            standing_reg    <= 1'b0;
            pushed_reg      <= 1'b0;
            last_reg        <= 1'b0;
            for (int i = 0; i < acp_pkg::AXES; i++)
            begin
                mover_pos_reg[i]  <= '0;
                mover_size_reg[i] <= acp_pkg::SIZE_RESET;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == acp_pkg::S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wen)
            begin
                case (cfg_index)
                    acp_pkg::CFG_SIZE_X: mover_size_reg[0] <= cfg_wdata;
                    acp_pkg::CFG_SIZE_Y: mover_size_reg[1] <= cfg_wdata;
                    acp_pkg::CFG_SIZE_Z: mover_size_reg[2] <= cfg_wdata;
                    default:             ;
                endcase
            end
            case (state_reg)
                acp_pkg::S_IDLE:
                begin
                    if (in_accept)
                    begin
                        ax_reg       <= acp_pkg::AXIS_X;
                        standing_reg <= 1'b0;
                        pushed_reg   <= 1'b0;
                        last_reg     <= (in_data.req_type == acp_pkg::REQ_OBSTACLE) &&
                                        in_data.frame_last;
                        if (in_data.req_type == acp_pkg::REQ_LOAD)
                        begin
                            mover_pos_reg[0] <= in_data.center_x;
                            mover_pos_reg[1] <= in_data.center_y;
                            mover_pos_reg[2] <= in_data.center_z;
                            floating_reg     <= in_data.floating_in;
                            any_support_reg  <= 1'b0;
                        end
                    end
                end
                acp_pkg::S_ABS:
                begin
                    neg_reg[ax_reg] <= diff_reg[acp_pkg::DIFF_WIDTH-1];
                end
                acp_pkg::S_CMP:
                begin
                    ovl_reg[ax_reg] <= twice_d < sum_ext;
                    if (ax_reg == acp_pkg::AXIS_Y)
                    begin
                        gap_reg <= twice_d < sum_ext +
                                   acp_pkg::CMP_WIDTH'(2 * acp_pkg::EPS_Q);
                    end
                    if (ax_reg != acp_pkg::AXIS_Z)
                    begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end
                acp_pkg::S_CHECK:
                begin
                    ax_reg       <= acp_pkg::AXIS_X;
                    best_reg     <= acp_pkg::AXIS_X;
                    best_inf_reg <= 1'b0;
                    standing_reg <= ovl_reg[0] && !ovl_reg[1] && ovl_reg[2] && gap_reg;
                end
                acp_pkg::S_SEL:
                begin
                    best_reg <= best_sel;
                    if (take_inf)
                    begin
                        best_inf_reg <= 1'b1;
                    end
                    ax_reg <= (ax_reg == acp_pkg::AXIS_Z) ? best_sel : ax_reg + 1'b1;
                end
                acp_pkg::S_PUSH:
                begin
                    mover_pos_reg[ax_reg] <= np_sat;
                    pushed_reg            <= 1'b1;
                    if (floating_reg)
                    begin
                        floating_reg <= 1'b0;
                        standing_reg <= 1'b1;
                    end
                end
                acp_pkg::S_FINISH:
                begin
                    if (out_free)
                    begin
                        floating_reg    <= floating_fin;
                        any_support_reg <= support_fin && !last_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            acp_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    in_reg <= in_data;
                end
            end
            acp_pkg::S_DIFF:
            begin
                diff_reg        <= diff_calc;
                sum_reg[ax_reg] <= acp_pkg::SUM_WIDTH'(cur_extent) +
                                   acp_pkg::SUM_WIDTH'(mover_size_reg[ax_reg]);
            end
            acp_pkg::S_ABS:
            begin
                d_reg[ax_reg] <= diff_reg[acp_pkg::DIFF_WIDTH-1] ?
                                 acp_pkg::DIFF_WIDTH'(-diff_reg) :
                                 acp_pkg::DIFF_WIDTH'(diff_reg);
            end
            acp_pkg::S_CHECK:
            begin
                best_d_reg <= '0;
                best_s_reg <= SW'(1);
            end
            acp_pkg::S_SEL:
            begin
                if (take_ratio)
                begin
                    best_d_reg <= d_small;
                    best_s_reg <= cur_extent;
                end
            end
            acp_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_data_reg.mover_x      <= mover_pos_reg[0];
                    out_data_reg.mover_y      <= mover_pos_reg[1];
                    out_data_reg.mover_z      <= mover_pos_reg[2];
                    out_data_reg.standing_on  <= standing_reg;
                    out_data_reg.pushed_out   <= pushed_reg;
                    out_data_reg.floating_out <= floating_fin;
                    out_data_reg.done_last    <= last_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != acp_pkg::S_IDLE)
        else $error("sequencer idle right after taking a word");

    a_post_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == acp_pkg::S_FINISH))
        else $error("result posted outside the finish step");

    a_ratio_on_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acp_pkg::S_MUL_A || state_reg == acp_pkg::S_MUL_B ||
         state_reg == acp_pkg::S_SEL || state_reg == acp_pkg::S_PUSH) |-> (&ovl_reg))
        else $error("axis selection without full overlap");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.pushed_out && out_data_reg.standing_on)
        |-> !out_data_reg.floating_out)
        else $error("landing push-out left the mover floating");
`endif

endmodule
